// ===== rtl/normal_color_vertex_shader_macros.svh =====
// assertion macros for the normal color vertex shader
`ifndef NORMAL_COLOR_VERTEX_SHADER_MACROS_SVH
`define NORMAL_COLOR_VERTEX_SHADER_MACROS_SVH
`ifndef SYNTHESIS
`define NCVS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NCVS_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define NCVS_ASSERT(name, clk, rst, prop, msg)
`define NCVS_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/ncvs_pkg.sv =====
// shared types and constants for the normal color vertex shader
`timescale 1ns / 1ps
package ncvs_pkg;
  localparam int LIGHTS = 3;
  localparam int AXES = 3;
  localparam int CHANNELS = 3;
  localparam int NRM_W = 16;
  localparam int DIR_W = 21;
  localparam int DIR_REG_W = 63;
  localparam int WGT_W = 12;
  localparam int WGT_REG_W = 36;
  localparam int AMB_W = 8;
  localparam int AMB_REG_W = 24;
  localparam int CNT_REG_W = 2;
  localparam int IR_W = 15;
  localparam int FRAC_SHIFT = 12;
  localparam int AMB_SHIFT = 16;
  // face code 128 then shift by 12 is a shift by 5
  localparam int FACE_SHIFT = 5;
  localparam int PROD_W = DIR_W + NRM_W;
  localparam int DOT_W = PROD_W + 2;
  localparam int CPROD_W = WGT_W + IR_W;
  localparam int CH_W = 29;
  localparam int BYTE_W = 8;
  localparam logic [IR_W-1:0] IR_MAX = 15'h7FFF;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_LIGHT0_DIR = 3'd0,
    REG_LIGHT1_DIR = 3'd1,
    REG_LIGHT2_DIR = 3'd2,
    REG_LIGHT0_WGT = 3'd3,
    REG_LIGHT1_WGT = 3'd4,
    REG_LIGHT2_WGT = 3'd5,
    REG_AMBIENT    = 3'd6,
    REG_LIGHT_CNT  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [LIGHTS-1:0][DIR_REG_W-1:0] dir;
    logic [LIGHTS-1:0][WGT_REG_W-1:0] wgt;
    logic [AMB_REG_W-1:0]             ambient;
    logic [CNT_REG_W-1:0]             count;
  } cfg_t;

  typedef logic [LIGHTS-1:0][IR_W-1:0] ir_vec_t;
endpackage

// ===== rtl/normal_color_vertex_shader.sv =====
// top level of the normal color vertex shader
// usage:
//   normal channel: normal_x, normal_y, normal_z with normal_valid; a word is
//   taken at a clock edge where normal_valid is high and normal_stall is low.
//   color channel: red, green, blue with color_valid; a word leaves at an edge
//   where color_valid is high and color_stall is low.
//   registers are written over the apb-style port at byte address 8*index;
//   the user must write only while no word is in flight; the block does not enforce it.
// path: an accepted normal passes the product register of the front, the queue,
//   the color product register of the back and the output register before
//   it shows on color_valid.
// throughput: one word per cycle while color_stall stays low; nine 21x16 and nine 12x15
//   multipliers work every cycle, one rank per pipeline stage.
// reset: synchronous, active high; registers return to zero except
//   light_count, which returns to 3, and the pipeline and queue empty.
// stall: a stalled color word holds; the back stops popping, the queue
//   fills, and normal_stall rises once queue words plus the word in flight
//   reach the queue depth.
`timescale 1ns / 1ps
module normal_color_vertex_shader #(
  parameter int DEPTH = ncvs_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ncvs_pkg::ADDR_W-1:0]          paddr,
  input  logic [ncvs_pkg::DATA_W-1:0]          pwdata,
  output logic [ncvs_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 normal_valid,
  output logic                                 normal_stall,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_x,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_y,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_z,
  output logic                                 color_valid,
  input  logic                                 color_stall,
  output logic [ncvs_pkg::BYTE_W-1:0]          red,
  output logic [ncvs_pkg::BYTE_W-1:0]          green,
  output logic [ncvs_pkg::BYTE_W-1:0]          blue
);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ncvs_pkg::cfg_t     cfg;
  logic               push;
  ncvs_pkg::ir_vec_t  push_data;
  logic               pop;
  ncvs_pkg::ir_vec_t  pop_data;
  logic               not_empty;
  logic [CNT_W-1:0]   level;

  ncvs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ncvs_front #(.DEPTH(DEPTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .normal_valid (normal_valid),
    .normal_stall (normal_stall),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .level        (level),
    .push         (push),
    .push_data    (push_data)
  );

  ncvs_queue #(.DEPTH(DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty),
    .level     (level)
  );

  ncvs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .not_empty   (not_empty),
    .pop_data    (pop_data),
    .pop         (pop),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );
endmodule

// ===== rtl/ncvs_regs.sv =====
// configuration register file behind the apb-style port
`timescale 1ns / 1ps
module ncvs_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ncvs_pkg::ADDR_W-1:0]   paddr,
  input  logic [ncvs_pkg::DATA_W-1:0]   pwdata,
  output logic [ncvs_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ncvs_pkg::cfg_t                cfg
);
  ncvs_pkg::reg_idx_t idx;
  logic               wr;

  assign idx = ncvs_pkg::reg_idx_t'(paddr[ncvs_pkg::ADDR_W-1:3]);
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dir <= '0;
      cfg.wgt <= '0;
      cfg.ambient <= '0;
      cfg.count <= ncvs_pkg::CNT_REG_W'(ncvs_pkg::LIGHTS);
    end else if (wr) begin
      case (idx)
        ncvs_pkg::REG_LIGHT0_DIR: cfg.dir[0] <= pwdata[ncvs_pkg::DIR_REG_W-1:0];
        ncvs_pkg::REG_LIGHT1_DIR: cfg.dir[1] <= pwdata[ncvs_pkg::DIR_REG_W-1:0];
        ncvs_pkg::REG_LIGHT2_DIR: cfg.dir[2] <= pwdata[ncvs_pkg::DIR_REG_W-1:0];
        ncvs_pkg::REG_LIGHT0_WGT: cfg.wgt[0] <= pwdata[ncvs_pkg::WGT_REG_W-1:0];
        ncvs_pkg::REG_LIGHT1_WGT: cfg.wgt[1] <= pwdata[ncvs_pkg::WGT_REG_W-1:0];
        ncvs_pkg::REG_LIGHT2_WGT: cfg.wgt[2] <= pwdata[ncvs_pkg::WGT_REG_W-1:0];
        ncvs_pkg::REG_AMBIENT:    cfg.ambient <= pwdata[ncvs_pkg::AMB_REG_W-1:0];
        ncvs_pkg::REG_LIGHT_CNT:  cfg.count <= pwdata[ncvs_pkg::CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ncvs_pkg::REG_LIGHT0_DIR: prdata = ncvs_pkg::DATA_W'(cfg.dir[0]);
      ncvs_pkg::REG_LIGHT1_DIR: prdata = ncvs_pkg::DATA_W'(cfg.dir[1]);
      ncvs_pkg::REG_LIGHT2_DIR: prdata = ncvs_pkg::DATA_W'(cfg.dir[2]);
      ncvs_pkg::REG_LIGHT0_WGT: prdata = ncvs_pkg::DATA_W'(cfg.wgt[0]);
      ncvs_pkg::REG_LIGHT1_WGT: prdata = ncvs_pkg::DATA_W'(cfg.wgt[1]);
      ncvs_pkg::REG_LIGHT2_WGT: prdata = ncvs_pkg::DATA_W'(cfg.wgt[2]);
      ncvs_pkg::REG_AMBIENT:    prdata = ncvs_pkg::DATA_W'(cfg.ambient);
      ncvs_pkg::REG_LIGHT_CNT:  prdata = ncvs_pkg::DATA_W'(cfg.count);
      default:                  prdata = '0;
    endcase
  end
endmodule

// ===== rtl/ncvs_front.sv =====
// front end: accepts normals and computes per-light intensities
`timescale 1ns / 1ps
`include "normal_color_vertex_shader_macros.svh"
module ncvs_front #(
  parameter int DEPTH = ncvs_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ncvs_pkg::cfg_t                       cfg,
  input  logic                                 normal_valid,
  output logic                                 normal_stall,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_x,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_y,
  input  logic signed [ncvs_pkg::NRM_W-1:0]    normal_z,
  input  logic [CNT_W-1:0]                     level,
  output logic                                 push,
  output ncvs_pkg::ir_vec_t                    push_data
);
  localparam int LVL_W = CNT_W + 1;
  localparam int HI = ncvs_pkg::FRAC_SHIFT + ncvs_pkg::IR_W;

  logic                                accept;
  logic                                a_valid;
  logic signed [ncvs_pkg::NRM_W-1:0]   nrm [ncvs_pkg::AXES];
  logic signed [ncvs_pkg::PROD_W-1:0]  prod [ncvs_pkg::LIGHTS][ncvs_pkg::AXES];
  logic signed [ncvs_pkg::PROD_W-1:0]  a_prod [ncvs_pkg::LIGHTS][ncvs_pkg::AXES];
  logic signed [ncvs_pkg::DOT_W-1:0]   dot [ncvs_pkg::LIGHTS];

  // credit check: queue words plus the word in flight
  assign normal_stall = ({1'b0, level} + LVL_W'(a_valid)) >= LVL_W'(DEPTH);
  assign accept = normal_valid && !normal_stall;
  assign push = a_valid;

  assign nrm[0] = normal_x;
  assign nrm[1] = normal_y;
  assign nrm[2] = normal_z;

  always_comb begin
    for (int i = 0; i < ncvs_pkg::LIGHTS; i++) begin
      for (int k = 0; k < ncvs_pkg::AXES; k++) begin
        prod[i][k] = ncvs_pkg::PROD_W'($signed(cfg.dir[i][ncvs_pkg::DIR_W*k +: ncvs_pkg::DIR_W]))
                   * ncvs_pkg::PROD_W'(nrm[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_prod <= prod;
    end
  end

  always_comb begin
    for (int i = 0; i < ncvs_pkg::LIGHTS; i++) begin
      dot[i] = ncvs_pkg::DOT_W'(a_prod[i][0]) + ncvs_pkg::DOT_W'(a_prod[i][1])
             + ncvs_pkg::DOT_W'(a_prod[i][2]);
      if (dot[i][ncvs_pkg::DOT_W-1] || (int'(cfg.count) <= i)) begin
        push_data[i] = '0;
      end else if (|dot[i][ncvs_pkg::DOT_W-2:HI]) begin
        push_data[i] = ncvs_pkg::IR_MAX;
      end else begin
        push_data[i] = dot[i][HI-1:ncvs_pkg::FRAC_SHIFT];
      end
    end
  end

  `NCVS_ASSERT(a_accept_push, clk, rst, accept |=> push, "accepted word did not reach queue")
endmodule

// ===== rtl/ncvs_queue.sv =====
// short queue of intensity words between front and back
`timescale 1ns / 1ps
`include "normal_color_vertex_shader_macros.svh"
module ncvs_queue #(
  parameter int DEPTH = ncvs_pkg::QUEUE_DEPTH,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  ncvs_pkg::ir_vec_t  push_data,
  input  logic               pop,
  output ncvs_pkg::ir_vec_t  pop_data,
  output logic               not_empty,
  output logic [CNT_W-1:0]   level
);
  ncvs_pkg::ir_vec_t mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  assign not_empty = (level != '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  `NCVS_NEVER(a_no_overflow, clk, rst, push && !pop && (level == CNT_W'(DEPTH)), "queue overflow")
  `NCVS_NEVER(a_no_underflow, clk, rst, pop && (level == '0), "queue underflow")
endmodule

// ===== rtl/ncvs_back.sv =====
// back end: color weighting, ambient, saturation and output register
`timescale 1ns / 1ps
`include "normal_color_vertex_shader_macros.svh"
module ncvs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ncvs_pkg::cfg_t                cfg,
  input  logic                          not_empty,
  input  ncvs_pkg::ir_vec_t             pop_data,
  output logic                          pop,
  output logic                          color_valid,
  input  logic                          color_stall,
  output logic [ncvs_pkg::BYTE_W-1:0]   red,
  output logic [ncvs_pkg::BYTE_W-1:0]   green,
  output logic [ncvs_pkg::BYTE_W-1:0]   blue
);
  localparam int HI = ncvs_pkg::FRAC_SHIFT + ncvs_pkg::IR_W;
  localparam int V_W = ncvs_pkg::IR_W - ncvs_pkg::FACE_SHIFT;

  logic                          ready_out;
  logic                          ready_c;
  logic                          c_valid;
  logic [ncvs_pkg::CPROD_W-1:0]  cprod [ncvs_pkg::CHANNELS][ncvs_pkg::LIGHTS];
  logic [ncvs_pkg::CPROD_W-1:0]  c_prod [ncvs_pkg::CHANNELS][ncvs_pkg::LIGHTS];
  logic [ncvs_pkg::CH_W-1:0]     chsum [ncvs_pkg::CHANNELS];
  logic [ncvs_pkg::IR_W-1:0]     lit [ncvs_pkg::CHANNELS];
  logic [V_W-1:0]                v [ncvs_pkg::CHANNELS];
  logic [ncvs_pkg::BYTE_W-1:0]   color [ncvs_pkg::CHANNELS];

  assign ready_out = !color_valid || !color_stall;
  assign ready_c = !c_valid || ready_out;
  assign pop = not_empty && ready_c;

  always_comb begin
    for (int c = 0; c < ncvs_pkg::CHANNELS; c++) begin
      for (int i = 0; i < ncvs_pkg::LIGHTS; i++) begin
        cprod[c][i] = ncvs_pkg::CPROD_W'(cfg.wgt[i][ncvs_pkg::WGT_W*c +: ncvs_pkg::WGT_W])
                    * ncvs_pkg::CPROD_W'(pop_data[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      color_valid <= 1'b0;
    end else begin
      if (ready_c) begin
        c_valid <= not_empty;
      end
      if (ready_out) begin
        color_valid <= c_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c_prod <= cprod;
    end
  end

  always_comb begin
    for (int c = 0; c < ncvs_pkg::CHANNELS; c++) begin
      chsum[c] = ncvs_pkg::CH_W'({cfg.ambient[ncvs_pkg::AMB_W*c +: ncvs_pkg::AMB_W],
                                   ncvs_pkg::AMB_SHIFT'(0)})
               + ncvs_pkg::CH_W'(c_prod[c][0])
               + ncvs_pkg::CH_W'(c_prod[c][1])
               + ncvs_pkg::CH_W'(c_prod[c][2]);
      if (|chsum[c][ncvs_pkg::CH_W-1:HI]) begin
        lit[c] = ncvs_pkg::IR_MAX;
      end else begin
        lit[c] = chsum[c][HI-1:ncvs_pkg::FRAC_SHIFT];
      end
      v[c] = lit[c][ncvs_pkg::IR_W-1:ncvs_pkg::FACE_SHIFT];
      if (|v[c][V_W-1:ncvs_pkg::BYTE_W]) begin
        color[c] = ncvs_pkg::BYTE_MAX;
      end else begin
        color[c] = v[c][ncvs_pkg::BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_out && c_valid) begin
      red <= color[0];
      green <= color[1];
      blue <= color[2];
    end
  end

  `NCVS_ASSERT(a_stage_to_out, clk, rst, (c_valid && ready_out) |=> color_valid, "word lost at output")
endmodule

// ===== tb/normal_color_vertex_shader_tb.sv =====
// self-checking testbench for normal_color_vertex_shader: directed table, random phases, apb setup
`timescale 1ns / 1ps
module normal_color_vertex_shader_tb;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 10;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int HOLD_CYCLES = 200;
  localparam int PRESSURE_PHASE = 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int FACE_CODE = 128;
  localparam int ROWS = 21;

  typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [ncvs_pkg::BYTE_W-1:0] r;
    logic [ncvs_pkg::BYTE_W-1:0] g;
    logic [ncvs_pkg::BYTE_W-1:0] b;
  } rgb_t;

  typedef struct {
    int                                 setting;
    logic signed [ncvs_pkg::NRM_W-1:0]  x;
    logic signed [ncvs_pkg::NRM_W-1:0]  y;
    logic signed [ncvs_pkg::NRM_W-1:0]  z;
    bit                                 known;
    rgb_t                               rgb;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ncvs_pkg::ADDR_W-1:0] paddr = '0;
  logic [ncvs_pkg::DATA_W-1:0] pwdata = '0;
  logic [ncvs_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic normal_valid = 1'b0;
  logic normal_stall;
  logic signed [ncvs_pkg::NRM_W-1:0] normal_x = '0;
  logic signed [ncvs_pkg::NRM_W-1:0] normal_y = '0;
  logic signed [ncvs_pkg::NRM_W-1:0] normal_z = '0;
  logic color_valid;
  logic color_stall = 1'b0;
  logic [ncvs_pkg::BYTE_W-1:0] red;
  logic [ncvs_pkg::BYTE_W-1:0] green;
  logic [ncvs_pkg::BYTE_W-1:0] blue;

  // register image kept alongside the block
  logic [ncvs_pkg::DIR_REG_W-1:0] dir_cfg [ncvs_pkg::LIGHTS] = '{default: '0};
  logic [ncvs_pkg::WGT_REG_W-1:0] wgt_cfg [ncvs_pkg::LIGHTS] = '{default: '0};
  logic [ncvs_pkg::AMB_REG_W-1:0] amb_cfg = '0;
  logic [ncvs_pkg::CNT_REG_W-1:0] cnt_cfg = 2'd3;

  rgb_t colors_due [$];
  int errors = 0;
  int cycles = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit known_now = 1'b0;
  rgb_t known_rgb = '0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  logic [63:0] setting_tab [5][8] = '{
    '{default: 64'h0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FF00_FF10, 64'hFFFF_FFFF_FFFF_FFFC},
    '{{1'b1, 21'h0, 21'h0, 21'h0FFFFF}, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      {28'hFFF_FFFF, 36'hFFF_FFF_FFF}, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
      {40'hFF_FFFF_FFFF, 24'h0}, 64'hFFFF_FFFF_FFFF_FFFD},
    '{{1'b1, 21'h100000, 21'h0FFFFF, 21'h100000}, {1'b0, 21'h0FFFFF, 21'h100000, 21'h0FFFFF},
      {1'b1, 21'h001000, 21'h1FF000, 21'h000800},
      {28'h0, 12'h123, 12'hFFF, 12'h000}, {28'hFFF_FFFF, 12'h040, 12'h800, 12'h0F0},
      {28'h0, 12'h010, 12'h020, 12'h030}, {40'h0, 24'h204080}, 64'd3},
    '{{1'b0, 21'h000400, 21'h000000, 21'h001000}, {1'b0, 21'h000000, 21'h000C00, 21'h1FFC00},
      {1'b1, 21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF},
      {28'h0, 36'h100_200_300}, {28'h0, 36'h0A0_0B0_0C0}, {28'hABC_DEF0, 36'hFFF_FFF_FFF},
      {40'h0, 24'h0A0B0C}, 64'hAAAA_AAAA_AAAA_AAAA}
  };

  stim_row_t dir_tab [ROWS] = '{
    // after reset every light weight and the ambient are zero
    '{0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 24'h000000},
    '{0, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 24'h000000},
    '{0, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 24'h000000},
    '{0, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, 24'h000000},
    // no lights, ambient only, upper bits of every write discarded
    '{1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 24'h087F00},
    '{1, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 24'h087F00},
    '{1, 16'sh1234, 16'shEDCB, 16'sh0FF0, 1'b1, 24'h087F00},
    // one light along x at full scale
    '{2, 16'sh7FFF, 16'sh0000, 16'sh0000, 1'b1, 24'hFFFFFF},
    '{2, 16'sh8000, 16'sh0000, 16'sh0000, 1'b1, 24'h000000},
    '{2, 16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 24'h000000},
    '{2, 16'sh1000, 16'sh8000, 16'sh7FFF, 1'b1, 24'hFFFFFF},
    '{2, 16'sh0001, 16'sh0000, 16'sh0000, 1'b0, 24'h000000},
    // three lights, direction extremes
    '{3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 24'h000000},
    '{3, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 24'h000000},
    '{3, 16'sh8000, 16'sh7FFF, 16'sh1000, 1'b0, 24'h000000},
    '{3, 16'sh1000, 16'sh0000, 16'shF000, 1'b0, 24'h000000},
    '{3, 16'sh0001, 16'shFFFF, 16'sh0800, 1'b0, 24'h000000},
    // two lights, a strong third light that must not count
    '{4, 16'sh1000, 16'sh1000, 16'sh1000, 1'b0, 24'h000000},
    '{4, 16'shF000, 16'sh0800, 16'sh0400, 1'b0, 24'h000000},
    '{4, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, 24'h000000},
    '{4, 16'sh0200, 16'sh0300, 16'shFE00, 1'b0, 24'h000000}
  };

  normal_color_vertex_shader u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .normal_valid (normal_valid),
    .normal_stall (normal_stall),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .color_valid  (color_valid),
    .color_stall  (color_stall),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

  always #5 clk = ~clk;

  function automatic int idle_pct(input idle_mode_t mode, input bit rx_side);
    if (mode == IDLE_BOTH) return 11;
    if (rx_side && mode == IDLE_RX) return 80;
    if (!rx_side && mode == IDLE_TX) return 80;
    return 0;
  endfunction

  function automatic longint clamp_ir(input longint acc);
    longint v;
    if (acc < 0) return 0;
    v = acc >>> ncvs_pkg::FRAC_SHIFT;
    return (v > longint'(ncvs_pkg::IR_MAX)) ? longint'(ncvs_pkg::IR_MAX) : v;
  endfunction

  function automatic rgb_t shade_vertex(input logic signed [ncvs_pkg::NRM_W-1:0] nx,
                                        input logic signed [ncvs_pkg::NRM_W-1:0] ny,
                                        input logic signed [ncvs_pkg::NRM_W-1:0] nz);
    longint nrm [ncvs_pkg::AXES];
    longint ir [ncvs_pkg::LIGHTS];
    longint acc;
    longint lit;
    logic [ncvs_pkg::BYTE_W-1:0] ch [ncvs_pkg::CHANNELS];
    logic signed [ncvs_pkg::DIR_W-1:0] comp;
    rgb_t res;
    nrm[0] = longint'(nx);
    nrm[1] = longint'(ny);
    nrm[2] = longint'(nz);
    for (int i = 0; i < ncvs_pkg::LIGHTS; i++) begin
      ir[i] = 0;
      if (i < int'(cnt_cfg)) begin
        acc = 0;
        for (int k = 0; k < ncvs_pkg::AXES; k++) begin
          comp = dir_cfg[i][ncvs_pkg::DIR_W*k +: ncvs_pkg::DIR_W];
          acc += longint'(comp) * nrm[k];
        end
        ir[i] = clamp_ir(acc);
      end
    end
    for (int c = 0; c < ncvs_pkg::CHANNELS; c++) begin
      acc = longint'(amb_cfg[ncvs_pkg::AMB_W*c +: ncvs_pkg::AMB_W]) << ncvs_pkg::AMB_SHIFT;
      for (int i = 0; i < ncvs_pkg::LIGHTS && i < int'(cnt_cfg); i++)
        acc += longint'(wgt_cfg[i][ncvs_pkg::WGT_W*c +: ncvs_pkg::WGT_W]) * ir[i];
      lit = (clamp_ir(acc) * FACE_CODE) >>> ncvs_pkg::FRAC_SHIFT;
      ch[c] = (lit > 255) ? ncvs_pkg::BYTE_MAX : lit[ncvs_pkg::BYTE_W-1:0];
    end
    res.r = ch[0];
    res.g = ch[1];
    res.b = ch[2];
    return res;
  endfunction

  function automatic logic [ncvs_pkg::DIR_W-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 21'h0FFFFF;
      1: return 21'h100000;
      2: return 21'h0;
      3, 4: return ncvs_pkg::DIR_W'($urandom);
      default: return ncvs_pkg::DIR_W'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic logic [ncvs_pkg::NRM_W-1:0] rand_norm();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4, 5: return ncvs_pkg::NRM_W'($urandom);
      default: return ncvs_pkg::NRM_W'($urandom_range(0, 8191) - 4096);
    endcase
  endfunction

  function automatic logic [ncvs_pkg::WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 12'hFFF;
      1: return 12'h000;
      2, 3: return {8'($urandom_range(0, 255)), 4'h0};
      default: return ncvs_pkg::WGT_W'($urandom);
    endcase
  endfunction

  // random bits above the register width, which the block must drop
  function automatic logic [63:0] with_junk(input logic [63:0] v, input int w);
    logic [63:0] mask;
    mask = (64'd1 << w) - 64'd1;
    return (v & mask) | ({$urandom, $urandom} & ~mask);
  endfunction

  task automatic make_setting(input int p, output logic [63:0] vals [8]);
    logic [ncvs_pkg::DIR_W-1:0] cx;
    logic [ncvs_pkg::DIR_W-1:0] cy;
    logic [ncvs_pkg::DIR_W-1:0] cz;
    for (int i = 0; i < ncvs_pkg::LIGHTS; i++) begin
      if (p == 0) begin
        cx = 21'h0FFFFF; cy = 21'h0FFFFF; cz = 21'h0FFFFF;
        vals[3+i] = with_junk({28'h0, 36'hFFF_FFF_FFF}, ncvs_pkg::WGT_REG_W);
      end else if (p == PHASES - 1) begin
        cx = 21'h100000; cy = 21'h100000; cz = 21'h100000;
        vals[3+i] = with_junk({28'h0, 36'hFFF_FFF_FFF}, ncvs_pkg::WGT_REG_W);
      end else begin
        cx = rand_comp(); cy = rand_comp(); cz = rand_comp();
        vals[3+i] = with_junk({28'h0, rand_weight(), rand_weight(), rand_weight()},
                              ncvs_pkg::WGT_REG_W);
      end
      vals[i] = with_junk({1'b0, cz, cy, cx}, ncvs_pkg::DIR_REG_W);
    end
    if (p == 0) begin
      vals[6] = with_junk(64'hFF_FFFF, ncvs_pkg::AMB_REG_W);
      vals[7] = with_junk(64'd3, ncvs_pkg::CNT_REG_W);
    end else if (p == PHASES - 1) begin
      vals[6] = with_junk(64'h0, ncvs_pkg::AMB_REG_W);
      vals[7] = with_junk(64'd3, ncvs_pkg::CNT_REG_W);
    end else begin
      vals[6] = with_junk({$urandom, $urandom}, ncvs_pkg::AMB_REG_W);
      vals[7] = with_junk(64'($urandom_range(0, 3)), ncvs_pkg::CNT_REG_W);
    end
  endtask

  task automatic write_reg(input ncvs_pkg::reg_idx_t idx, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ncvs_pkg::ADDR_W'(int'(idx) * 8);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      ncvs_pkg::REG_LIGHT0_DIR, ncvs_pkg::REG_LIGHT1_DIR, ncvs_pkg::REG_LIGHT2_DIR:
        dir_cfg[int'(idx) - int'(ncvs_pkg::REG_LIGHT0_DIR)] = data[ncvs_pkg::DIR_REG_W-1:0];
      ncvs_pkg::REG_LIGHT0_WGT, ncvs_pkg::REG_LIGHT1_WGT, ncvs_pkg::REG_LIGHT2_WGT:
        wgt_cfg[int'(idx) - int'(ncvs_pkg::REG_LIGHT0_WGT)] = data[ncvs_pkg::WGT_REG_W-1:0];
      ncvs_pkg::REG_AMBIENT: amb_cfg = data[ncvs_pkg::AMB_REG_W-1:0];
      ncvs_pkg::REG_LIGHT_CNT: cnt_cfg = data[ncvs_pkg::CNT_REG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [63:0] vals [8]);
    for (int i = 0; i < 8; i++)
      write_reg(ncvs_pkg::reg_idx_t'(i), vals[i]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (colors_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_normal(input logic signed [ncvs_pkg::NRM_W-1:0] x,
                             input logic signed [ncvs_pkg::NRM_W-1:0] y,
                             input logic signed [ncvs_pkg::NRM_W-1:0] z,
                             input bit known, input rgb_t rgb);
    int pct;
    pct = idle_pct(idle_mode, 1'b0);
    while ($urandom_range(0, 99) < pct) begin
      normal_valid <= 1'b0;
      @(posedge clk);
    end
    normal_valid <= 1'b1;
    normal_x <= x;
    normal_y <= y;
    normal_z <= z;
    known_now <= known;
    known_rgb <= rgb;
    @(posedge clk);
    while (normal_stall) @(posedge clk);
  endtask

  // receiver: random stall plus the long hold-off
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
    color_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(idle_mode, 1'b1));
  end

  // accepted normal word
  always @(posedge clk) begin
    if (!rst && normal_valid && !normal_stall)
      colors_due.push_back(known_now ? known_rgb : shade_vertex(normal_x, normal_y, normal_z));
  end

  // accepted color word
  always @(posedge clk) begin
    rgb_t want;
    if (!rst && color_valid && !color_stall) begin
      if (colors_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected color word r %0d g %0d b %0d", red, green, blue);
      end else begin
        want = colors_due.pop_front();
        if (want.r !== red || want.g !== green || want.b !== blue) begin
          errors++;
          if (errors <= 10)
            $display("color mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                     want.r, want.g, want.b, red, green, blue);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int cur;
    logic [63:0] vals [8];
    cur = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].setting != cur) begin
        normal_valid <= 1'b0;
        settle();
        cur = dir_tab[r].setting;
        load_setting(setting_tab[cur]);
      end
      send_normal(dir_tab[r].x, dir_tab[r].y, dir_tab[r].z, dir_tab[r].known, dir_tab[r].rgb);
    end

    for (int p = 0; p < PHASES; p++) begin
      normal_valid <= 1'b0;
      settle();
      make_setting(p, vals);
      load_setting(vals);
      idle_mode = idle_mode_t'(p % 4);
      if (p == PRESSURE_PHASE) hold_req = ~hold_req;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_normal(rand_norm(), rand_norm(), rand_norm(), 1'b0, '0);
    end

    normal_valid <= 1'b0;
    settle();
    if (errors == 0 && colors_due.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
